// File: design/ghp_pkg.sv
`default_nettype none

package ghp_pkg;

    localparam int unsigned POOL_SLOTS_DEFAULT = 1024;
    localparam int unsigned GEN_W = 8;
    localparam int unsigned CMD_W = 2;
    localparam logic [GEN_W-1:0] GEN_LIMIT_RESET = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CHECK  = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

// File: design/ghp_ram.sv
`default_nettype none

module ghp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/ghp_ctrl.sv
`default_nettype none

module ghp_ctrl
    import ghp_pkg::*;
#(
    parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [GEN_W-1:0]                 cfg_wr_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [CMD_W-1:0]                 cmd,
    input  wire logic                             handle_initialized,
    input  wire logic [$clog2(POOL_SLOTS)-1:0]    handle_index,
    input  wire logic [GEN_W-1:0]                 handle_generation,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  ok,
    output logic      [$clog2(POOL_SLOTS)-1:0]    new_index,
    output logic      [GEN_W-1:0]                 new_generation,
    output logic      [$clog2(POOL_SLOTS+1)-1:0]  free_count,
    output logic                                  stk_we,
    output logic      [$clog2(POOL_SLOTS)-1:0]    stk_waddr,
    output logic      [$clog2(POOL_SLOTS)-1:0]    stk_wdata,
    output logic                                  stk_re,
    output logic      [$clog2(POOL_SLOTS)-1:0]    stk_raddr,
    input  wire logic [$clog2(POOL_SLOTS)-1:0]    stk_rdata,
    output logic                                  gen_we,
    output logic      [$clog2(POOL_SLOTS)-1:0]    gen_waddr,
    output logic      [GEN_W-1:0]                 gen_wdata,
    output logic                                  gen_re,
    output logic      [$clog2(POOL_SLOTS)-1:0]    gen_raddr,
    input  wire logic [GEN_W-1:0]                 gen_rdata
);

    localparam int unsigned IDX_W = $clog2(POOL_SLOTS);
    localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_SLOTS);
    localparam logic [IDX_W:0]   RANGE_END = (IDX_W+1)'(POOL_SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_POP,
        ST_GENCHK
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic             init_reg, init_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [GEN_W-1:0] hgen_reg, hgen_next;
    logic             inrange_reg, inrange_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cand_reg, cand_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [GEN_W-1:0] limit_reg, limit_next;
    logic             out_valid_reg, out_valid_next;
    logic             ok_reg, ok_next;
    logic [IDX_W-1:0] nidx_reg, nidx_next;
    logic [GEN_W-1:0] ngen_reg, ngen_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;

    logic             out_free;
    logic             in_range;
    logic             handle_valid;
    logic             fin;
    logic             res_ok;
    logic [IDX_W-1:0] res_idx;
    logic [GEN_W-1:0] res_gen;
    logic [CNT_W-1:0] count_dec;

    assign out_free     = !out_valid_reg || !out_stall;
    assign in_range     = {1'b0, handle_index} < RANGE_END;
    assign handle_valid = init_reg && inrange_reg && (gen_rdata == hgen_reg);
    assign count_dec    = count_reg - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        init_next    = init_reg;
        idx_next     = idx_reg;
        hgen_next    = hgen_reg;
        inrange_next = inrange_reg;
        count_next   = count_reg;
        cand_next    = cand_reg;
        clr_next     = clr_reg;
        limit_next   = cfg_wr_en ? cfg_wr_data : limit_reg;
        fin          = 1'b0;
        res_ok       = 1'b0;
        res_idx      = '0;
        res_gen      = '0;
        stk_we       = 1'b0;
        stk_waddr    = '0;
        stk_wdata    = '0;
        stk_re       = 1'b0;
        stk_raddr    = '0;
        gen_we       = 1'b0;
        gen_waddr    = '0;
        gen_wdata    = '0;
        gen_re       = 1'b0;
        gen_raddr    = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                stk_we    = 1'b1;
                stk_waddr = clr_reg;
                stk_wdata = LAST_IDX - clr_reg;
                gen_we    = 1'b1;
                gen_waddr = clr_reg;
                gen_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd_t'(cmd);
                    init_next    = handle_initialized;
                    idx_next     = handle_index;
                    hgen_next    = handle_generation;
                    inrange_next = in_range;
                    if (cmd_t'(cmd) == CMD_CREATE && count_reg != '0)
                    begin
                        stk_re     = 1'b1;
                        stk_raddr  = count_dec[IDX_W-1:0];
                        state_next = ST_POP;
                    end
                    else
                    begin
                        gen_re     = in_range;
                        gen_raddr  = handle_index;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_POP:
            begin
                cand_next  = stk_rdata;
                gen_re     = 1'b1;
                gen_raddr  = stk_rdata;
                count_next = count_dec;
                state_next = ST_GENCHK;
            end
            ST_GENCHK:
            begin
                priority if (gen_rdata < limit_reg)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        res_ok     = 1'b1;
                        res_idx    = cand_reg;
                        res_gen    = gen_rdata;
                        state_next = ST_IDLE;
                    end
                end
                else if (count_reg != '0)
                begin
                    stk_re     = 1'b1;
                    stk_raddr  = count_dec[IDX_W-1:0];
                    state_next = ST_POP;
                end
                else
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                    unique case (cmd_reg)
                        CMD_DELETE:
                        begin
                            if (handle_valid && count_reg < FULL_CNT)
                            begin
                                stk_we     = 1'b1;
                                stk_waddr  = count_reg[IDX_W-1:0];
                                stk_wdata  = idx_reg;
                                gen_we     = 1'b1;
                                gen_waddr  = idx_reg;
                                gen_wdata  = gen_rdata + 1'b1;
                                count_next = count_reg + 1'b1;
                                res_ok     = 1'b1;
                            end
                        end
                        CMD_CHECK:
                        begin
                            res_ok = handle_valid;
                        end
                        default:
                        begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        nidx_next      = nidx_reg;
        ngen_next      = ngen_reg;
        fcnt_next      = fcnt_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
            ok_next        = res_ok;
            nidx_next      = res_idx;
            ngen_next      = res_gen;
            fcnt_next      = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmd_reg       <= CMD_CREATE;
            init_reg      <= 1'b0;
            idx_reg       <= '0;
            hgen_reg      <= '0;
            inrange_reg   <= 1'b0;
            count_reg     <= FULL_CNT;
            cand_reg      <= '0;
            clr_reg       <= '0;
            limit_reg     <= GEN_LIMIT_RESET;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            nidx_reg      <= '0;
            ngen_reg      <= '0;
            fcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            init_reg      <= init_next;
            idx_reg       <= idx_next;
            hgen_reg      <= hgen_next;
            inrange_reg   <= inrange_next;
            count_reg     <= count_next;
            cand_reg      <= cand_next;
            clr_reg       <= clr_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            nidx_reg      <= nidx_next;
            ngen_reg      <= ngen_next;
            fcnt_reg      <= fcnt_next;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign new_index      = nidx_reg;
    assign new_generation = ngen_reg;
    assign free_count     = fcnt_reg;

endmodule

`default_nettype wire

// File: design/generational_handle_pool.sv
// Handle allocator with a per-slot generation and a stack of free slots, both held in
// single-port-read synchronous memories. After reset the block runs a clearing pass
// (one slot a cycle) that loads the free stack and zeroes every generation; in_stall
// stays high meanwhile, though generation limit writes are taken. Check and delete
// first read the slot's generation, then compare and write back once the output
// register is free. Create reads the top of the free stack, then the popped slot's
// generation, and pops and drops each retired slot whose generation has reached the
// limit; create on an empty pool fails without a stack read. A finished result
// waits in the output register while the next command is accepted.
`default_nettype none

module generational_handle_pool
    import ghp_pkg::*;
#(
    parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [GEN_W-1:0]                 cfg_wr_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [CMD_W-1:0]                 cmd,
    input  wire logic                             handle_initialized,
    input  wire logic [$clog2(POOL_SLOTS)-1:0]    handle_index,
    input  wire logic [GEN_W-1:0]                 handle_generation,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  ok,
    output logic      [$clog2(POOL_SLOTS)-1:0]    new_index,
    output logic      [GEN_W-1:0]                 new_generation,
    output logic      [$clog2(POOL_SLOTS+1)-1:0]  free_count
);

    localparam int unsigned IDX_W = $clog2(POOL_SLOTS);

    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [IDX_W-1:0] stk_wdata;
    logic             stk_re;
    logic [IDX_W-1:0] stk_raddr;
    logic [IDX_W-1:0] stk_rdata;
    logic             gen_we;
    logic [IDX_W-1:0] gen_waddr;
    logic [GEN_W-1:0] gen_wdata;
    logic             gen_re;
    logic [IDX_W-1:0] gen_raddr;
    logic [GEN_W-1:0] gen_rdata;

    ghp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_SLOTS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    ghp_ram #(
        .WIDTH (GEN_W),
        .DEPTH (POOL_SLOTS)
    ) u_gen_ram (
        .clk     (clk),
        .wr_en   (gen_we),
        .wr_addr (gen_waddr),
        .wr_data (gen_wdata),
        .rd_en   (gen_re),
        .rd_addr (gen_raddr),
        .rd_data (gen_rdata)
    );

    ghp_ctrl #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .cmd                (cmd),
        .handle_initialized (handle_initialized),
        .handle_index       (handle_index),
        .handle_generation  (handle_generation),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .ok                 (ok),
        .new_index          (new_index),
        .new_generation     (new_generation),
        .free_count         (free_count),
        .stk_we             (stk_we),
        .stk_waddr          (stk_waddr),
        .stk_wdata          (stk_wdata),
        .stk_re             (stk_re),
        .stk_raddr          (stk_raddr),
        .stk_rdata          (stk_rdata),
        .gen_we             (gen_we),
        .gen_waddr          (gen_waddr),
        .gen_wdata          (gen_wdata),
        .gen_re             (gen_re),
        .gen_raddr          (gen_raddr),
        .gen_rdata          (gen_rdata)
    );

endmodule

`default_nettype wire
